### rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants, types and state codes of the three-voice sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int unsigned PHASE_BITS_DEF = 24;
  localparam int unsigned WAVE_STEPS     = 32;
  localparam int unsigned NUM_VOICES     = 3;

  localparam logic [31:0] PHASE_RATE_RST = 32'd131072000;

  // divider widths: dividend holds phase_rate or the scaled mix, divisor the period or mix scale
  localparam int unsigned DIV_W   = 48;
  localparam int unsigned DIVS_W  = 32;
  localparam int unsigned DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [DIVS_W-1:0] MIX_DEN = 32'd442368000;

  localparam int unsigned SIG_W = 20;
  localparam int unsigned ACC_W = 30;
  localparam logic signed [SIG_W-1:0] FULL_UNIT = 20'sd491520;

  // wave select codes
  localparam logic [1:0] WSEL_SQUARE = 2'd0;
  localparam logic [1:0] WSEL_NOISE  = 2'd2;

  // combine modes
  localparam logic [3:0] CMB_OFF  = 4'd0;
  localparam logic [3:0] CMB_AND  = 4'd1;
  localparam logic [3:0] CMB_NAND = 4'd2;
  localparam logic [3:0] CMB_OR   = 4'd3;
  localparam logic [3:0] CMB_NOR  = 4'd4;
  localparam logic [3:0] CMB_XOR  = 4'd5;
  localparam logic [3:0] CMB_XNOR = 4'd6;

  // request types
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // config register byte address
  localparam logic [2:0] CFG_PHASE_RATE = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSTART,
    ST_VDIV,
    ST_MIX,
    ST_FSTART,
    ST_FDIV,
    ST_FINISH
  } psg_state_e;

  typedef struct packed {
    logic [1:0] wsel;
    logic [3:0] duty;
    logic       use_wave;
    logic       noise_cur;
  } voice_ctl_t;

  typedef struct packed {
    logic signed [SIG_W-1:0] sig;
    logic [3:0]              lvl;
    logic                    lfsr_step;
    logic                    noise_nxt;
  } voice_res_t;

  // (2n - 15) * 32768 for a 4-bit level
  function automatic logic signed [SIG_W-1:0] level_sig(input logic [3:0] n);
    logic signed [5:0] w;
    w = $signed({1'b0, n, 1'b0}) - 6'sd15;
    return {w[4:0], 15'b0};
  endfunction

endpackage

### rtl/psg_div.sv
// ----------------------------------------------------------------------------
// psg_div
// Bit-serial restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module psg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psg_pkg::DIV_W-1:0]     dividend_i,
  input  logic [psg_pkg::DIVS_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [psg_pkg::DIV_W-1:0]     quotient_o
);
  import psg_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic [DIVS_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]    quo_q, quo_d;
  logic [DIVS_W-1:0]   dsr_q, dsr_d;
  logic [DIVS_W:0]     trial;
  logic                ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIV_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DIVS_W'(trial - {1'b0, dsr_q}) : trial[DIVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/psg_voice.sv
// ----------------------------------------------------------------------------
// psg_voice
// Waveform evaluation of one voice from its phase, with noise LFSR update.
// ----------------------------------------------------------------------------
module psg_voice #(
  parameter int unsigned PHASE_BITS = psg_pkg::PHASE_BITS_DEF
) (
  input  psg_pkg::voice_ctl_t  ctl_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  input  logic [PHASE_BITS-1:0] phase_nxt_i,
  input  logic [127:0]          wave_i,
  input  logic [16:0]           lfsr_i,
  output logic [16:0]           lfsr_nxt_o,
  output psg_pkg::voice_res_t   res_o
);
  import psg_pkg::*;

  logic                  wrap;
  logic [4:0]            step;
  logic [15:0]           word;
  logic [3:0]            nib;
  logic [15:0]           u;
  logic [19:0]           u15;
  logic                  noise_hit;
  logic [PHASE_BITS+3:0] ph15;
  logic                  sq_hi;
  logic [PHASE_BITS+15:0] ph_wide;
  logic [15:0]           s16;
  logic [16:0]           x16;
  logic signed [17:0]    xd;
  logic signed [21:0]    saw_sig;
  logic [20:0]           q_raw;
  logic [4:0]            q5;

  assign wrap = phase_nxt_i < phase_i;

  assign step = phase_i[PHASE_BITS-1 -: 5];

  always_comb begin
    case (step[4:2])
      3'd0:    word = wave_i[15:0];
      3'd1:    word = wave_i[31:16];
      3'd2:    word = wave_i[47:32];
      3'd3:    word = wave_i[63:48];
      3'd4:    word = wave_i[79:64];
      3'd5:    word = wave_i[95:80];
      3'd6:    word = wave_i[111:96];
      default: word = wave_i[127:112];
    endcase
    case (step[1:0])
      2'd0:    nib = word[15:12];
      2'd1:    nib = word[11:8];
      2'd2:    nib = word[7:4];
      default: nib = word[3:0];
    endcase
  end

  // x^17 + x^14 + 1, shifting right
  assign lfsr_nxt_o = {lfsr_i[0] ^ lfsr_i[3], lfsr_i[16:1]};
  assign u          = lfsr_nxt_o[15:0];
  assign u15        = ({4'b0, u} << 4) - {4'b0, u};
  assign noise_hit  = (ctl_i.duty == '0) ? !u[15] : (u15 < {ctl_i.duty, 16'b0});

  assign ph15  = ({4'b0, phase_i} << 4) - {4'b0, phase_i};
  assign sq_hi = (ctl_i.duty == '0) ? !phase_i[PHASE_BITS-1]
                                    : (ph15 < {ctl_i.duty, {PHASE_BITS{1'b0}}});

  assign ph_wide = {phase_i, 16'b0} >> PHASE_BITS;
  assign s16     = ph_wide[15:0];
  assign x16     = (ctl_i.duty != '0) ? (17'h10000 - {1'b0, s16}) : {1'b0, s16};
  assign xd      = $signed({1'b0, x16}) - 18'sd32768;
  assign saw_sig = ($signed({{4{xd[17]}}, xd}) <<< 4) - $signed({{4{xd[17]}}, xd});
  assign q_raw   = ((21'({x16, 4'b0}) - 21'(x16)) + 21'd32768);
  assign q5      = q_raw[20:16];

  always_comb begin
    res_o.lfsr_step = 1'b0;
    res_o.noise_nxt = ctl_i.noise_cur;
    if (ctl_i.use_wave) begin
      res_o.sig = level_sig(nib);
      res_o.lvl = nib;
    end else if (ctl_i.wsel == WSEL_NOISE) begin
      if (wrap) begin
        res_o.lfsr_step = 1'b1;
        res_o.noise_nxt = noise_hit;
      end
      res_o.sig = res_o.noise_nxt ? FULL_UNIT : -FULL_UNIT;
      res_o.lvl = res_o.noise_nxt ? 4'd15 : 4'd0;
    end else if (ctl_i.wsel == WSEL_SQUARE) begin
      res_o.sig = sq_hi ? FULL_UNIT : -FULL_UNIT;
      res_o.lvl = sq_hi ? 4'd15 : 4'd0;
    end else begin
      res_o.sig = saw_sig[SIG_W-1:0];
      res_o.lvl = (q5 > 5'd15) ? 4'd15 : q5[3:0];
    end
  end

endmodule

### rtl/three_voice_psg_sample_generator.sv
// ----------------------------------------------------------------------------
// three_voice_psg_sample_generator
// Three-voice sound generator producing one stereo PCM sample per tick.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): an item is a register write
// (req_type_i = 1, stores write_data_i at reg_addr_i) or a sample tick.
// A write is taken without stalling the input and gives no output. A tick yields one
// sample pair on the output channel (out_valid_o / out_stall_i).
// Per tick each voice with a nonzero period runs one 48-step bit-serial
// division of phase_rate by its period (a silent voice is skipped), then
// the voices are mixed and a final 48-step division by the mix scale runs.
// One tick is processed at a time; the shared serial divider sets the rate.
// The sample sits in an output register; a new item is taken while it
// waits, and a following tick holds in its last step until it is taken.
// The APB port reads phase_rate at byte address 0 and writes it at byte addresses 0 to 3.
// Reset clears all control and wavetable words, phases and noise levels,
// sets the LFSR to one and phase_rate to its default.
// ----------------------------------------------------------------------------
module three_voice_psg_sample_generator #(
  parameter int unsigned PHASE_BITS = psg_pkg::PHASE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [3:0]         reg_addr_i,
  input  logic [15:0]        write_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import psg_pkg::*;

  psg_state_e state_q, state_d;

  logic [31:0]           phase_rate_q;
  logic [15:0]           ctrl_q [8];
  logic [15:0]           wave_q [8];
  logic [PHASE_BITS-1:0] phase_q [NUM_VOICES];
  logic                  noise_q [NUM_VOICES];
  logic [16:0]           lfsr_q;
  logic [1:0]            v_q, v_d;
  logic signed [SIG_W-1:0] sig_q [NUM_VOICES];
  logic                  act_q [NUM_VOICES];
  logic [3:0]            lvl1_q, lvl2_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [15:0]    res_q;
  logic                  out_valid_q;
  logic signed [15:0]    out_q;

  logic                  in_xfer, out_xfer, cfg_wr;
  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_dividend, div_quo;
  logic [DIVS_W-1:0]     div_divisor;
  logic [15:0]           period;
  logic [3:0]            shift_sel_duty;
  logic [1:0]            shift_sel_wsel;
  voice_ctl_t            vctl;
  voice_res_t            vres;
  logic [16:0]           lfsr_nxt;
  logic [PHASE_BITS-1:0] phase_cur, phase_nxt;
  logic [127:0]          wave_flat;
  logic                  voice_done, last_voice;
  logic                  load_out;
  logic [3:0]            mode, cmb;
  logic [3:0]            vol, master;
  logic [7:0]            vm;
  logic signed [SIG_W-1:0] mix_sig;
  logic signed [28:0]    prod;
  logic                  neg;
  logic [ACC_W-1:0]      mag;
  logic [15:0]           qmag;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = (paddr == CFG_PHASE_RATE) ? phase_rate_q : '0;

  // per-voice field selection
  always_comb begin
    case (v_q)
      2'd0: begin
        period         = ctrl_q[4];
        shift_sel_wsel = ctrl_q[2][9:8];
        shift_sel_duty = ctrl_q[3][11:8];
        vol            = ctrl_q[0][7:4];
      end
      2'd1: begin
        period         = ctrl_q[5];
        shift_sel_wsel = ctrl_q[2][5:4];
        shift_sel_duty = ctrl_q[3][7:4];
        vol            = ctrl_q[0][3:0];
      end
      default: begin
        period         = ctrl_q[6];
        shift_sel_wsel = ctrl_q[2][1:0];
        shift_sel_duty = ctrl_q[3][3:0];
        vol            = ctrl_q[1][11:8];
      end
    endcase
  end

  assign phase_cur = phase_q[v_q];
  assign phase_nxt = phase_cur + div_quo[PHASE_BITS-1:0];
  assign wave_flat = {wave_q[7], wave_q[6], wave_q[5], wave_q[4],
                      wave_q[3], wave_q[2], wave_q[1], wave_q[0]};

  assign vctl.wsel      = shift_sel_wsel;
  assign vctl.duty      = shift_sel_duty;
  assign vctl.use_wave  = (v_q == 2'd2) && (ctrl_q[1][7:4] != 4'd0);
  assign vctl.noise_cur = noise_q[v_q];

  psg_voice #(
    .PHASE_BITS(PHASE_BITS)
  ) u_voice (
    .ctl_i      (vctl),
    .phase_i    (phase_cur),
    .phase_nxt_i(phase_nxt),
    .wave_i     (wave_flat),
    .lfsr_i     (lfsr_q),
    .lfsr_nxt_o (lfsr_nxt),
    .res_o      (vres)
  );

  // combine of voices 1 and 2
  assign mode = (ctrl_q[2][15:12] > CMB_XNOR) ? CMB_XNOR : ctrl_q[2][15:12];
  always_comb begin
    case (mode)
      CMB_AND:  cmb = lvl1_q & lvl2_q;
      CMB_NAND: cmb = ~(lvl1_q & lvl2_q);
      CMB_OR:   cmb = lvl1_q | lvl2_q;
      CMB_NOR:  cmb = ~(lvl1_q | lvl2_q);
      CMB_XOR:  cmb = lvl1_q ^ lvl2_q;
      default:  cmb = ~(lvl1_q ^ lvl2_q);
    endcase
  end

  assign master = ctrl_q[0][11:8];
  assign vm     = vol * master;

  always_comb begin
    mix_sig = sig_q[v_q];
    if ((v_q == 2'd1) && (mode != CMB_OFF) && act_q[1] && act_q[2]) begin
      mix_sig = level_sig(cmb);
    end
  end

  assign prod = mix_sig * $signed({1'b0, vm});

  // final scaling: |acc| * 32767 / MIX_DEN
  assign neg  = acc_q[ACC_W-1];
  assign mag  = neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign qmag = div_quo[15:0];

  assign voice_done = (state_q == ST_VDIV && div_done) ||
                      (state_q == ST_VSTART && period == '0);
  assign last_voice = (v_q == 2'd2);
  assign load_out   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_xfer && req_type_i == REQ_TICK) state_d = ST_VSTART;
      ST_VSTART: begin
        if (period == '0) state_d = last_voice ? ST_MIX : ST_VSTART;
        else              state_d = ST_VDIV;
      end
      ST_VDIV:   if (div_done) state_d = last_voice ? ST_MIX : ST_VSTART;
      ST_MIX:    if (last_voice) state_d = ST_FSTART;
      ST_FSTART: state_d = ST_FDIV;
      ST_FDIV:   if (div_done) state_d = ST_FINISH;
      ST_FINISH: if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {{(DIV_W-32){1'b0}}, phase_rate_q};
    div_divisor  = {{(DIVS_W-16){1'b0}}, period};
    v_d          = v_q;
    acc_d        = acc_q;
    case (state_q)
      ST_IDLE: begin
        v_d   = 2'd0;
        acc_d = '0;
      end
      ST_VSTART: begin
        div_start = (period != '0);
        if (period == '0) v_d = last_voice ? 2'd0 : v_q + 2'd1;
      end
      ST_VDIV: if (div_done) v_d = last_voice ? 2'd0 : v_q + 2'd1;
      ST_MIX: begin
        acc_d = acc_q + ACC_W'(prod);
        v_d   = last_voice ? 2'd0 : v_q + 2'd1;
      end
      ST_FSTART: begin
        div_start    = 1'b1;
        div_dividend = ({{(DIV_W-ACC_W){1'b0}}, mag} << 15) -
                       {{(DIV_W-ACC_W){1'b0}}, mag};
        div_divisor  = MIX_DEN;
      end
      default: ;
    endcase
  end

  psg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_rate_q <= PHASE_RATE_RST;
      lfsr_q       <= 17'd1;
      v_q          <= 2'd0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        ctrl_q[i] <= '0;
        wave_q[i] <= '0;
      end
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase_q[i] <= '0;
        noise_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      if (cfg_wr && !paddr[2]) phase_rate_q <= pwdata;
      if (in_xfer && req_type_i == REQ_WRITE) begin
        if (!reg_addr_i[3]) ctrl_q[reg_addr_i[2:0]] <= write_data_i;
        else                wave_q[reg_addr_i[2:0]] <= write_data_i;
      end
      if (state_q == ST_VDIV && div_done) begin
        phase_q[v_q] <= phase_nxt;
        noise_q[v_q] <= vres.noise_nxt;
        if (vres.lfsr_step) lfsr_q <= lfsr_nxt;
      end
      if (load_out)      out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (voice_done) begin
      act_q[v_q] <= (state_q == ST_VDIV);
      sig_q[v_q] <= (state_q == ST_VDIV) ? vres.sig : '0;
      if (v_q == 2'd1) lvl1_q <= vres.lvl;
      if (v_q == 2'd2) lvl2_q <= vres.lvl;
    end
    if (state_q == ST_FDIV && div_done) res_q <= neg ? -$signed(qmag) : $signed(qmag);
    if (load_out) out_q <= res_q;
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = out_q;
  assign right_sample_o = out_q;

endmodule

### rtl/psg_checker.sv
// ----------------------------------------------------------------------------
// psg_checker
// Port-level checks of the sound generator, bound to the top level.
// ----------------------------------------------------------------------------
module psg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               req_type_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] left_sample_o,
  input logic signed [15:0] right_sample_o,
  input logic               pready
);
  import psg_pkg::*;

  // stalled sample holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_sample_o))
    else $error("stalled output changed");

  a_stereo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_sample_o == right_sample_o)
    else $error("left and right differ");

  // a tick keeps the block busy for the next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_TICK |=> in_stall_o)
    else $error("tick did not occupy the block");

  // a register write does not stall the input
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_WRITE |=> !in_stall_o)
    else $error("register write stalled input");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind three_voice_psg_sample_generator psg_checker u_psg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .req_type_i    (req_type_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .left_sample_o (left_sample_o),
  .right_sample_o(right_sample_o),
  .pready        (pready)
);
